// ===== rtl/zctt_pkg.sv =====
// ----------------------------------------------------------------------------
// zctt_pkg
// Types and constants shared by the zero-crossing tone tracker modules.
// ----------------------------------------------------------------------------
package zctt_pkg;

    localparam int unsigned ZERO_LEVEL  = 128;
    localparam int unsigned PIT_CLOCK   = 1193180;
    localparam int unsigned FREQ_MAX    = 3200;
    localparam int unsigned FREQ_MIN    = 110;
    localparam int unsigned LEVEL_MIN   = 3;
    localparam int unsigned COUNT_MAX   = 127;
    localparam int unsigned SUM_MAX     = 16383;

    localparam int unsigned RATE_RESET  = 8000;
    localparam int unsigned VOL_RESET   = 80;

    localparam int unsigned SAMPLE_W    = 8;
    localparam int unsigned CROSS_W     = 7;
    localparam int unsigned SUM_W       = 14;
    localparam int unsigned RATE_W      = 18;
    localparam int unsigned VOL_W       = 7;
    localparam int unsigned FREQ_W      = 12;
    localparam int unsigned PITDIV_W    = 16;
    localparam int unsigned MEAN_W      = 7;

    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 18;

    // crossings * sample rate
    localparam int unsigned PROD_W      = 25;

    // divider sized for the timer divisor: 1193180 over a 12-bit frequency
    localparam int unsigned DIV_NUM_W   = 21;
    localparam int unsigned DIV_DEN_W   = 12;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE = 1'b0,
        CFG_VOLUME      = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                flush;
    } t_in;

    typedef struct packed {
        logic                tone_on;
        logic [FREQ_W-1:0]   tone_freq;
        logic [PITDIV_W-1:0] timer_divisor;
        logic [CROSS_W-1:0]  crossings;
        logic [MEAN_W-1:0]   mean_level;
    } t_out;

    // one finished window handed from front to back
    typedef struct packed {
        logic [CROSS_W-1:0] crossings;
        logic [SUM_W-1:0]   mag_sum;
    } t_win;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN,
        ST_MUL,
        ST_FREQ,
        ST_PIT,
        ST_DONE
    } t_back_state;

endpackage

// ===== rtl/zctt_front.sv =====
// ----------------------------------------------------------------------------
// zctt_front
// Per-sample crossing count and magnitude sum; pushes one entry per window.
// ----------------------------------------------------------------------------
module zctt_front #(
    parameter int unsigned WINDOW = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  zctt_pkg::t_in i_in,
    output logic          o_win_push,
    output zctt_pkg::t_win o_win
);
    import zctt_pkg::*;

    localparam int unsigned POS_W = $clog2(WINDOW);

    logic [SAMPLE_W-1:0] r_prev;
    logic [POS_W-1:0]    r_pos;
    logic [CROSS_W-1:0]  r_cross;
    logic [SUM_W-1:0]    r_sum;

    logic [SAMPLE_W-1:0] n_prev;
    logic [POS_W-1:0]    n_pos;
    logic [CROSS_W-1:0]  n_cross;
    logic [SUM_W-1:0]    n_sum;

    logic [SAMPLE_W-1:0] mag;
    logic [SUM_W:0]      sum_add;
    logic                crossed;
    logic                last;
    logic [CROSS_W-1:0]  cross_upd;
    logic [SUM_W-1:0]    sum_upd;

    always_comb begin
        if (r_prev >= SAMPLE_W'(ZERO_LEVEL)) begin
            mag = r_prev - SAMPLE_W'(ZERO_LEVEL);
        end else begin
            mag = SAMPLE_W'(ZERO_LEVEL) - r_prev;
        end
        crossed = (r_prev[SAMPLE_W-1] != i_in.sample[SAMPLE_W-1]);
        sum_add = {1'b0, r_sum} + (SUM_W+1)'(mag);
        // first sample of a window has no pair yet
        if (r_pos != '0) begin
            cross_upd = (crossed && r_cross != CROSS_W'(COUNT_MAX)) ? r_cross + 1'b1 : r_cross;
            sum_upd   = (sum_add > (SUM_W+1)'(SUM_MAX)) ? SUM_W'(SUM_MAX) : sum_add[SUM_W-1:0];
        end else begin
            cross_upd = r_cross;
            sum_upd   = r_sum;
        end
        last = (r_pos == POS_W'(WINDOW - 1)) || i_in.flush;

        n_prev  = r_prev;
        n_pos   = r_pos;
        n_cross = r_cross;
        n_sum   = r_sum;
        if (i_accept) begin
            n_prev = i_in.sample;
            if (last) begin
                n_pos   = '0;
                n_cross = '0;
                n_sum   = '0;
            end else begin
                n_pos   = r_pos + 1'b1;
                n_cross = cross_upd;
                n_sum   = sum_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= SAMPLE_W'(ZERO_LEVEL);
            r_pos   <= '0;
            r_cross <= '0;
            r_sum   <= '0;
        end else begin
            r_prev  <= n_prev;
            r_pos   <= n_pos;
            r_cross <= n_cross;
            r_sum   <= n_sum;
        end
    end

    assign o_win_push      = i_accept && last;
    assign o_win.crossings = cross_upd;
    assign o_win.mag_sum   = sum_upd;

endmodule

// ===== rtl/zctt_fifo.sv =====
// ----------------------------------------------------------------------------
// zctt_fifo
// Short queue of finished windows between front and back.
// ----------------------------------------------------------------------------
module zctt_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  zctt_pkg::t_win i_wr_data,
    input  logic           i_rd,
    output zctt_pkg::t_win o_rd_data,
    output logic           o_full,
    output logic           o_empty
);
    import zctt_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_win             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign do_wr = i_wr && !o_full;
    assign do_rd = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // depth is a power of two, pointers wrap by themselves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);

endmodule

// ===== rtl/zctt_div.sv =====
// ----------------------------------------------------------------------------
// zctt_div
// Restoring divider, one quotient bit per cycle, used by the back end for the timer divisor.
// ----------------------------------------------------------------------------
module zctt_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  zctt_pkg::t_div_req i_req,
    output zctt_pkg::t_div_rsp o_rsp
);
    import zctt_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   trial;
    logic                 q_bit;

    always_comb begin
        trial = {r_rem, r_num[DIV_NUM_W-1]};
        q_bit = (trial >= {1'b0, r_den});
    end

    // quotient bits shift in behind the numerator
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], q_bit};
            if (q_bit) begin
                r_rem <= DIV_DEN_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DIV_DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt  <= r_cnt - 1'b1;
                r_busy <= (r_cnt != CNT_W'(1));
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

// ===== rtl/zctt_back.sv =====
// ----------------------------------------------------------------------------
// zctt_back
// Per-window evaluation: mean level, frequency, timer divisor, result register.
// ----------------------------------------------------------------------------
module zctt_back #(
    parameter int unsigned WINDOW = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_win_avail,
    input  zctt_pkg::t_win                i_win,
    output logic                          o_win_pop,
    input  logic [zctt_pkg::RATE_W-1:0]   i_sample_rate,
    input  logic [zctt_pkg::VOL_W-1:0]    i_volume,
    output logic                          o_empty,
    input  logic                          i_pop,
    output zctt_pkg::t_out                o_out
);
    import zctt_pkg::*;

    // division by the window length is a multiply by a rounded-up reciprocal,
    // exact for every numerator of the given width
    localparam int unsigned     WIN_LOG    = $clog2(WINDOW);
    localparam int unsigned     MEAN_SHIFT = SUM_W + WIN_LOG;
    localparam longint unsigned MEAN_RECIP = ((64'd1 << MEAN_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int unsigned     MPROD_W    = 2 * SUM_W + 1;
    localparam int unsigned     FREQ_SHIFT = PROD_W + $clog2(2 * WINDOW);
    localparam longint unsigned FREQ_RECIP =
        ((64'd1 << FREQ_SHIFT) + 2 * WINDOW - 1) / (2 * WINDOW);
    localparam int unsigned     FPROD_W    = 2 * PROD_W + 1;

    t_back_state          r_state;
    t_back_state          n_state;
    logic [CROSS_W-1:0]   r_cross;
    logic [CROSS_W-1:0]   n_cross;
    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     n_sum;
    logic [MEAN_W-1:0]    r_mean;
    logic [MEAN_W-1:0]    n_mean;
    logic [PROD_W-1:0]    r_prod;
    logic [PROD_W-1:0]    n_prod;
    logic [PROD_W-1:0]    r_fq;
    logic [PROD_W-1:0]    n_fq;
    logic [FREQ_W-1:0]    r_freq;
    logic [FREQ_W-1:0]    n_freq;
    logic [PITDIV_W-1:0]  r_pitdiv;
    logic [PITDIV_W-1:0]  n_pitdiv;
    logic                 r_on;
    logic                 n_on;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_out                 r_out;
    t_out                 n_out;

    t_div_req             div_req;
    t_div_rsp             div_rsp;
    logic                 out_take;
    logic [FREQ_W-1:0]    freq_clamped;
    logic [MPROD_W-1:0]   mean_prod;
    logic [SUM_W-1:0]     mean_full;
    logic [FPROD_W-1:0]   fq_prod;

    zctt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_take = i_pop && r_out_valid;

    always_comb begin
        mean_prod = MPROD_W'(r_sum) * MPROD_W'(MEAN_RECIP);
        mean_full = SUM_W'(mean_prod >> MEAN_SHIFT);
        fq_prod   = FPROD_W'(r_prod) * FPROD_W'(FREQ_RECIP);
    end

    always_comb begin
        if (r_fq < PROD_W'(FREQ_MIN)) begin
            freq_clamped = FREQ_W'(FREQ_MIN);
        end else if (r_fq > PROD_W'(FREQ_MAX)) begin
            freq_clamped = FREQ_W'(FREQ_MAX);
        end else begin
            freq_clamped = r_fq[FREQ_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cross     = r_cross;
        n_sum       = r_sum;
        n_mean      = r_mean;
        n_prod      = r_prod;
        n_fq        = r_fq;
        n_freq      = r_freq;
        n_pitdiv    = r_pitdiv;
        n_on        = r_on;
        n_out_valid = r_out_valid && !out_take;
        n_out       = r_out;
        o_win_pop   = 1'b0;
        div_req     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_win_avail) begin
                    o_win_pop = 1'b1;
                    n_cross   = i_win.crossings;
                    n_sum     = i_win.mag_sum;
                    n_state   = ST_MEAN;
                end
            end
            ST_MEAN: begin
                n_mean   = mean_full[MEAN_W-1:0];
                n_prod   = PROD_W'(r_cross) * PROD_W'(i_sample_rate);
                n_freq   = '0;
                n_pitdiv = '0;
                n_on     = 1'b0;
                if (mean_full >= SUM_W'(LEVEL_MIN) && i_volume != '0) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MUL: begin
                n_fq    = PROD_W'(fq_prod >> FREQ_SHIFT);
                n_state = ST_FREQ;
            end
            ST_FREQ: begin
                n_freq        = freq_clamped;
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'(PIT_CLOCK);
                div_req.den   = freq_clamped;
                n_state       = ST_PIT;
            end
            ST_PIT: begin
                if (div_rsp.done) begin
                    n_pitdiv = div_rsp.quot[PITDIV_W-1:0];
                    n_on     = 1'b1;
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the result register to drain
                if (!r_out_valid || out_take) begin
                    n_out_valid         = 1'b1;
                    n_out.tone_on       = r_on;
                    n_out.tone_freq     = r_freq;
                    n_out.timer_divisor = r_pitdiv;
                    n_out.crossings     = r_cross;
                    n_out.mean_level    = r_mean;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cross  <= n_cross;
        r_sum    <= n_sum;
        r_mean   <= n_mean;
        r_prod   <= n_prod;
        r_fq     <= n_fq;
        r_freq   <= n_freq;
        r_pitdiv <= n_pitdiv;
        r_on     <= n_on;
        r_out    <= n_out;
    end

    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

endmodule

// ===== rtl/zero_crossing_tone_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// zero_crossing_tone_tracker_unit
// Zero-crossing tone tracker: windowed crossing count to speaker tone.
// ----------------------------------------------------------------------------
// Input channel: push/full. One 8-bit offset-binary sample per beat, with a
// flush bit that closes the current window after that sample. Samples are
// taken one per cycle while full is low.
// Result channel: empty/pop. One result per window (WINDOW samples or fewer
// on flush), oldest first, held on o_out while empty is low.
// Configuration: i_cfg_we with index 0 = sample rate, 1 = volume; write only
// when the block is idle.
// Back end: a window taken from the queue passes the mean, multiply,
// frequency and timer-divisor states to the result register (a window with
// the tone off goes from the mean state straight to the result). It handles one
// window at a time and is busy mostly in the one-bit-per-cycle divider doing
// the 21-step timer divisor division. A two-entry window queue lets the front
// end keep taking samples meanwhile; full rises only when that queue is full.
// Reset (synchronous, active low) empties everything and restores the
// registers to 8000 Hz and volume 80. A stalled receiver holds the result;
// the back end then waits and, once the queue fills, full goes high.
// ----------------------------------------------------------------------------
module zero_crossing_tone_tracker_unit #(
    parameter int unsigned WINDOW = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  zctt_pkg::t_in                     i_in,
    output logic                              empty,
    input  logic                              pop,
    output zctt_pkg::t_out                    o_out,
    input  logic                              i_cfg_we,
    input  logic [zctt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [zctt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import zctt_pkg::*;

    logic [RATE_W-1:0] r_sample_rate;
    logic [VOL_W-1:0]  r_volume;

    logic accept;
    logic win_push;
    t_win win_wr;
    t_win win_rd;
    logic win_pop;
    logic q_full;
    logic q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= RATE_W'(RATE_RESET);
            r_volume      <= VOL_W'(VOL_RESET);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[RATE_W-1:0];
                CFG_VOLUME:      r_volume      <= i_cfg_data[VOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    zctt_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in       (i_in),
        .o_win_push (win_push),
        .o_win      (win_wr)
    );

    zctt_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (win_push),
        .i_wr_data (win_wr),
        .i_rd      (win_pop),
        .o_rd_data (win_rd),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    zctt_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_win_avail   (!q_empty),
        .i_win         (win_rd),
        .o_win_pop     (win_pop),
        .i_sample_rate (r_sample_rate),
        .i_volume      (r_volume),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_out         (o_out)
    );

endmodule

// ===== rtl/zctt_chk.sv =====
// ----------------------------------------------------------------------------
// zctt_chk
// Port-level checks for the tone tracker, bound to the top level.
// ----------------------------------------------------------------------------
module zctt_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           full,
    input logic           empty,
    input logic           pop,
    input zctt_pkg::t_out o_out
);
    import zctt_pkg::*;

    // held result beat must not change or vanish
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("result changed while stalled");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out.tone_on) |->
            (o_out.tone_freq == '0 && o_out.timer_divisor == '0))
        else $error("silent result with nonzero frequency or divisor");

    a_on_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.tone_on) |->
            (o_out.tone_freq >= FREQ_W'(FREQ_MIN) && o_out.tone_freq <= FREQ_W'(FREQ_MAX)
             && o_out.timer_divisor != '0))
        else $error("tone frequency outside clamp range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

endmodule

bind zero_crossing_tone_tracker_unit zctt_chk u_zctt_chk (.*);
